[hw/rtl/bius_pkg.sv]
// Shared types, widths and codes for the best-IoU ROI selector.
`default_nettype none

package bius_pkg;

   // Field widths
   localparam int COORD_BITS = 16;
   localparam int SIZE_BITS  = 12;

   // Right/bottom edges carry one extra bit so they never wrap
   localparam int EDGE_BITS  = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 1;
   localparam int DIFF_BITS  = EDGE_BITS + 1;
   localparam int AREA_BITS  = 2 * SIZE_BITS;
   localparam int UNION_BITS = AREA_BITS + 1;
   localparam int PROD_BITS  = AREA_BITS + UNION_BITS;

   // CSR port geometry
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Register indexes (byte address = 4 * index)
   typedef enum logic [1:0] {
      REG_REF_LEFT   = 2'd0,
      REG_REF_TOP    = 2'd1,
      REG_REF_WIDTH  = 2'd2,
      REG_REF_HEIGHT = 2'd3
   } bius_reg_type;

   // Back-end sequencer states
   typedef enum logic {
      BACK_IDLE = 1'b0,
      BACK_CMP  = 1'b1
   } bius_back_state_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] left;
      logic signed [COORD_BITS-1:0] top;
      logic        [SIZE_BITS-1:0]  width;
      logic        [SIZE_BITS-1:0]  height;
   } bius_rect_type;

   // One classified candidate waiting for the compare
   typedef struct packed {
      bius_rect_type               rect;
      logic [AREA_BITS-1:0]        inter;
      logic [UNION_BITS-1:0]       uni;
      logic                        group_end;
   } bius_entry_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } bius_qflags_type;

endpackage

`default_nettype wire

[hw/rtl/bius_req_if.sv]
// Candidate input channel: valid/ready handshake with candidate payload.
`default_nettype none

interface bius_req_if
   import bius_pkg::*;
();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] cand_left;
   logic signed [COORD_BITS-1:0] cand_top;
   logic        [SIZE_BITS-1:0]  cand_width;
   logic        [SIZE_BITS-1:0]  cand_height;
   logic                         group_end;

   modport source (
      output valid, cand_left, cand_top, cand_width, cand_height, group_end,
      input  ready
   );

   modport sink (
      input  valid, cand_left, cand_top, cand_width, cand_height, group_end,
      output ready
   );
endinterface

`default_nettype wire

[hw/rtl/bius_rsp_if.sv]
// Result output channel: valid/ready handshake with best-rectangle payload.
`default_nettype none

interface bius_rsp_if
   import bius_pkg::*;
();
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic signed [COORD_BITS-1:0] best_left;
   logic signed [COORD_BITS-1:0] best_top;
   logic        [SIZE_BITS-1:0]  best_width;
   logic        [SIZE_BITS-1:0]  best_height;

   modport source (
      output valid, found, best_left, best_top, best_width, best_height,
      input  ready
   );

   modport sink (
      input  valid, found, best_left, best_top, best_width, best_height,
      output ready
   );
endinterface

`default_nettype wire

[hw/rtl/bius_front.sv]
// Front end: reference-box CSRs, candidate intake, intersection and union areas.
`default_nettype none

module bius_front
   import bius_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // CSR port
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output      logic [CSR_DATA_BITS-1:0] csr_prdata,
   // candidate channel
   bius_req_if.sink                      req_chan,
   // queue write side
   input  wire bius_qflags_type          qflags,
   output      logic                     push,
   output      bius_entry_type           push_entry
);

   // Reference box registers
   logic signed [COORD_BITS-1:0] ref_left_ff,   ref_left_in;
   logic signed [COORD_BITS-1:0] ref_top_ff,    ref_top_in;
   logic        [SIZE_BITS-1:0]  ref_width_ff,  ref_width_in;
   logic        [SIZE_BITS-1:0]  ref_height_ff, ref_height_in;
   logic        [AREA_BITS-1:0]  ref_area_ff,   ref_area_in;

   logic         csr_wr;
   bius_reg_type csr_reg;

   // Intake stage
   logic                  a_valid_ff,  a_valid_in;
   bius_rect_type         a_rect_ff,   a_rect_in;
   logic                  a_end_ff,    a_end_in;
   logic [SIZE_BITS-1:0]  a_dx_ff,     a_dx_in;
   logic [SIZE_BITS-1:0]  a_dy_ff,     a_dy_in;
   logic [AREA_BITS-1:0]  a_area_ff,   a_area_in;

   logic                         accept;
   logic signed [EDGE_BITS-1:0]  cand_x2, cand_y2, ref_x2, ref_y2;
   logic signed [EDGE_BITS-1:0]  min_x2, min_y2;
   logic signed [COORD_BITS-1:0] max_x1, max_y1;
   logic signed [DIFF_BITS-1:0]  diff_x, diff_y;
   logic [AREA_BITS-1:0]         inter;

   // CSR decode; low address bits are ignored
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg = bius_reg_type'(csr_paddr[3:2]);

   always_comb begin
      ref_left_in   = ref_left_ff;
      ref_top_in    = ref_top_ff;
      ref_width_in  = ref_width_ff;
      ref_height_in = ref_height_ff;
      if (csr_wr) begin
         case (csr_reg)
            REG_REF_LEFT:   ref_left_in   = signed'(csr_pwdata[COORD_BITS-1:0]);
            REG_REF_TOP:    ref_top_in    = signed'(csr_pwdata[COORD_BITS-1:0]);
            REG_REF_WIDTH:  ref_width_in  = csr_pwdata[SIZE_BITS-1:0];
            REG_REF_HEIGHT: ref_height_in = csr_pwdata[SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Reference area is registered from the size registers, so it follows them in the next cycle
   assign ref_area_in = AREA_BITS'(ref_width_ff) * AREA_BITS'(ref_height_ff);

   // Read-back
   always_comb begin
      case (csr_reg)
         REG_REF_LEFT:   csr_prdata = CSR_DATA_BITS'($unsigned(ref_left_ff));
         REG_REF_TOP:    csr_prdata = CSR_DATA_BITS'($unsigned(ref_top_ff));
         REG_REF_WIDTH:  csr_prdata = CSR_DATA_BITS'(ref_width_ff);
         REG_REF_HEIGHT: csr_prdata = CSR_DATA_BITS'(ref_height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Handshake: the intake stage drains into the queue
   assign push           = a_valid_ff && !qflags.full;
   assign req_chan.ready = !a_valid_ff || !qflags.full;
   assign accept         = req_chan.valid && req_chan.ready;

   // Edges and overlap extents
   always_comb begin
      cand_x2 = EDGE_BITS'(req_chan.cand_left) + $signed(EDGE_BITS'(req_chan.cand_width));
      cand_y2 = EDGE_BITS'(req_chan.cand_top)  + $signed(EDGE_BITS'(req_chan.cand_height));
      ref_x2  = EDGE_BITS'(ref_left_ff) + $signed(EDGE_BITS'(ref_width_ff));
      ref_y2  = EDGE_BITS'(ref_top_ff)  + $signed(EDGE_BITS'(ref_height_ff));
      max_x1  = (req_chan.cand_left > ref_left_ff) ? req_chan.cand_left : ref_left_ff;
      max_y1  = (req_chan.cand_top  > ref_top_ff)  ? req_chan.cand_top  : ref_top_ff;
      min_x2  = (cand_x2 < ref_x2) ? cand_x2 : ref_x2;
      min_y2  = (cand_y2 < ref_y2) ? cand_y2 : ref_y2;
      diff_x  = DIFF_BITS'(min_x2) - DIFF_BITS'(max_x1);
      diff_y  = DIFF_BITS'(min_y2) - DIFF_BITS'(max_y1);
   end

   // Non-positive extent clips to zero, which zeroes the intersection
   always_comb begin
      a_valid_in       = accept ? 1'b1 : (push ? 1'b0 : a_valid_ff);
      a_rect_in.left   = req_chan.cand_left;
      a_rect_in.top    = req_chan.cand_top;
      a_rect_in.width  = req_chan.cand_width;
      a_rect_in.height = req_chan.cand_height;
      a_end_in         = req_chan.group_end;
      a_dx_in          = (diff_x > 0) ? diff_x[SIZE_BITS-1:0] : '0;
      a_dy_in          = (diff_y > 0) ? diff_y[SIZE_BITS-1:0] : '0;
      a_area_in        = AREA_BITS'(req_chan.cand_width) * AREA_BITS'(req_chan.cand_height);
   end

   // Intersection and union into the queue entry
   assign inter                = AREA_BITS'(a_dx_ff) * AREA_BITS'(a_dy_ff);
   assign push_entry.rect      = a_rect_ff;
   assign push_entry.inter     = inter;
   assign push_entry.uni       = UNION_BITS'(a_area_ff) + UNION_BITS'(ref_area_ff)
                                 - UNION_BITS'(inter);
   assign push_entry.group_end = a_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_left_ff   <= '0;
         ref_top_ff    <= '0;
         ref_width_ff  <= '0;
         ref_height_ff <= '0;
         ref_area_ff   <= '0;
         a_valid_ff    <= 1'b0;
      end else begin
         ref_left_ff   <= ref_left_in;
         ref_top_ff    <= ref_top_in;
         ref_width_ff  <= ref_width_in;
         ref_height_ff <= ref_height_in;
         ref_area_ff   <= ref_area_in;
         a_valid_ff    <= a_valid_in;
      end
   end

   // Payload of the intake stage
   always_ff @(posedge clock) begin
      if (accept) begin
         a_rect_ff <= a_rect_in;
         a_end_ff  <= a_end_in;
         a_dx_ff   <= a_dx_in;
         a_dy_ff   <= a_dy_in;
         a_area_ff <= a_area_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bius_queue.sv]
// Two-entry register queue between the front end and the compare back end.
`default_nettype none

module bius_queue
   import bius_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire bius_entry_type  push_entry,
   input  wire logic            pop,
   output      bius_entry_type  head,
   output      bius_qflags_type qflags
);

   bius_entry_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff,  count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign qflags.full  = (count_ff == 2'd2);
   assign qflags.empty = (count_ff == 2'd0);

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bius_back.sv]
// Back end: cross-multiplied IoU compare, running best and result register.
`default_nettype none

module bius_back
   import bius_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire bius_entry_type  head,
   input  wire bius_qflags_type qflags,
   output      logic            pop,
   bius_rsp_if.source           rsp_chan
);

   bius_back_state_type state_ff, state_in;

   // Running best
   logic [AREA_BITS-1:0]  best_inter_ff, best_inter_in;
   logic [UNION_BITS-1:0] best_union_ff, best_union_in;
   bius_rect_type         best_rect_ff,  best_rect_in;
   logic                  have_best_ff,  have_best_in;

   // Item under compare and its products
   bius_entry_type        work_ff;
   logic [PROD_BITS-1:0]  prod_a_ff, prod_a_in;
   logic [PROD_BITS-1:0]  prod_b_ff, prod_b_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff;
   bius_rect_type         rsp_rect_ff;

   logic          slot_free;
   logic          win;
   logic          upd_have;
   bius_rect_type upd_rect;
   logic          load;
   logic          commit;
   logic          emit;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // inter/uni > best_inter/best_union, compared as cross products
   assign prod_a_in = PROD_BITS'(head.inter) * PROD_BITS'(best_union_ff);
   assign prod_b_in = PROD_BITS'(best_inter_ff) * PROD_BITS'(head.uni);
   assign win       = (work_ff.uni != '0) && (prod_a_ff > prod_b_ff);
   assign upd_have  = have_best_ff || win;
   assign upd_rect  = win ? work_ff.rect : best_rect_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!qflags.empty) begin
               state_in = BACK_CMP;
            end
         end
         BACK_CMP: begin
            if (!work_ff.group_end || slot_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      load   = 1'b0;
      commit = 1'b0;
      emit   = 1'b0;
      case (state_ff)
         BACK_IDLE: load   = !qflags.empty;
         BACK_CMP: begin
            commit = !work_ff.group_end;
            emit   = work_ff.group_end && slot_free;
         end
         default: ;
      endcase
   end

   assign pop = load;

   // Best update; a group end restores the cleared values
   always_comb begin
      best_inter_in = best_inter_ff;
      best_union_in = best_union_ff;
      best_rect_in  = best_rect_ff;
      have_best_in  = have_best_ff;
      if (emit) begin
         best_inter_in = '0;
         best_union_in = UNION_BITS'(1);
         best_rect_in  = '0;
         have_best_in  = 1'b0;
      end else if (commit && win) begin
         best_inter_in = work_ff.inter;
         best_union_in = work_ff.uni;
         best_rect_in  = work_ff.rect;
         have_best_in  = 1'b1;
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_IDLE;
         best_inter_ff <= '0;
         best_union_ff <= UNION_BITS'(1);
         best_rect_ff  <= '0;
         have_best_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         best_inter_ff <= best_inter_in;
         best_union_ff <= best_union_in;
         best_rect_ff  <= best_rect_in;
         have_best_ff  <= have_best_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         work_ff   <= head;
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
      if (emit) begin
         rsp_found_ff <= upd_have;
         rsp_rect_ff  <= upd_rect;
      end
   end

   // Best rect stays zero until a win, so fields read zero when not found
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.best_left   = rsp_rect_ff.left;
   assign rsp_chan.best_top    = rsp_rect_ff.top;
   assign rsp_chan.best_width  = rsp_rect_ff.width;
   assign rsp_chan.best_height = rsp_rect_ff.height;

endmodule

`default_nettype wire

[hw/rtl/best_iou_roi_selector_core.sv]
// A group-end beat passes the intake stage, the queue, the back-end work registers
// and the result register. The back-end sequencer compares each candidate before it
// loads the next; the front end and a two-entry queue absorb short stalls.
// Reset (synchronous): clears the reference box to zero, empties the queue and
// the result register, and restores the running best to its cleared values.
// Top level: ties the front end, the candidate queue and the compare back end.
`default_nettype none

module best_iou_roi_selector_core
   import bius_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // CSR port
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output      logic [CSR_DATA_BITS-1:0] csr_prdata,
   output      logic                     csr_pready,
   // channels
   bius_req_if.sink                      req_chan,
   bius_rsp_if.source                    rsp_chan
);

   logic            push;
   logic            pop;
   bius_entry_type  push_entry;
   bius_entry_type  head;
   bius_qflags_type qflags;

   assign csr_pready = 1'b1;

   bius_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .req_chan    (req_chan),
      .qflags      (qflags),
      .push        (push),
      .push_entry  (push_entry)
   );

   bius_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qflags     (qflags)
   );

   bius_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .qflags   (qflags),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

[bench/best_iou_roi_selector_core_tb.sv]
// Testbench for the best-IoU ROI selector: drives candidate groups and checks each picked box.
module best_iou_roi_selector_core_tb;
   import bius_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 125;

   // One expected pick: found flag plus the winning box
   typedef struct packed {
      logic          found;
      bius_rect_type box;
   } roi_pick_type;

   // Tracks the running best box per group and the picks still owed by the block
   class iou_pick_tracker;
      logic signed [COORD_BITS-1:0] ref_left;
      logic signed [COORD_BITS-1:0] ref_top;
      logic        [SIZE_BITS-1:0]  ref_width;
      logic        [SIZE_BITS-1:0]  ref_height;
      longint                       best_inter;
      longint                       best_union;
      bius_rect_type                best_box;
      bit                           have_best;
      roi_pick_type                 expected_picks[$];
      int                           errors;

      function new();
         ref_left   = '0;
         ref_top    = '0;
         ref_width  = '0;
         ref_height = '0;
         errors     = 0;
         clear_running();
      endfunction

      function void clear_running();
         best_inter = 0;
         best_union = 1;
         best_box   = '0;
         have_best  = 1'b0;
      endfunction

      function void write_register(bius_reg_type idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            REG_REF_LEFT:   ref_left   = data[COORD_BITS-1:0];
            REG_REF_TOP:    ref_top    = data[COORD_BITS-1:0];
            REG_REF_WIDTH:  ref_width  = data[SIZE_BITS-1:0];
            REG_REF_HEIGHT: ref_height = data[SIZE_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Intersection/union of one candidate, then exact cross-multiplied compare
      function void note_candidate(bius_rect_type cand, logic last);
         longint       c_x1, c_y1, c_x2, c_y2;
         longint       r_x1, r_y1, r_x2, r_y2;
         longint       ix1, iy1, ix2, iy2;
         longint       inter, uni;
         roi_pick_type pick;
         c_x1 = $signed(cand.left);
         c_y1 = $signed(cand.top);
         c_x2 = c_x1 + longint'(cand.width);
         c_y2 = c_y1 + longint'(cand.height);
         r_x1 = $signed(ref_left);
         r_y1 = $signed(ref_top);
         r_x2 = r_x1 + longint'(ref_width);
         r_y2 = r_y1 + longint'(ref_height);
         ix1 = (c_x1 > r_x1) ? c_x1 : r_x1;
         iy1 = (c_y1 > r_y1) ? c_y1 : r_y1;
         ix2 = (c_x2 < r_x2) ? c_x2 : r_x2;
         iy2 = (c_y2 < r_y2) ? c_y2 : r_y2;
         inter = 0;
         if (ix2 > ix1 && iy2 > iy1) begin
            inter = (ix2 - ix1) * (iy2 - iy1);
         end
         uni = longint'(cand.width) * longint'(cand.height)
             + longint'(ref_width) * longint'(ref_height) - inter;
         // strictly greater only: the first of equal candidates stays
         if (uni != 0 && inter * best_union > best_inter * uni) begin
            best_inter = inter;
            best_union = uni;
            best_box   = cand;
            have_best  = 1'b1;
         end
         if (last) begin
            pick.found = have_best;
            pick.box   = have_best ? best_box : '0;
            expected_picks = {expected_picks, pick};
            clear_running();
         end
      endfunction

      function void compare_field(string field, longint want_v, longint got_v);
         if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want_v, got_v);
            errors++;
         end
      endfunction

      function void check_pick(logic found, bius_rect_type box);
         roi_pick_type want;
         if (expected_picks.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual found=%0d box=(%0d,%0d,%0d,%0d)",
                     $time, found, box.left, box.top, box.width, box.height);
            errors++;
            return;
         end
         want = expected_picks.pop_front();
         compare_field("found", want.found, found);
         compare_field("best_left", $signed(want.box.left), $signed(box.left));
         compare_field("best_top", $signed(want.box.top), $signed(box.top));
         compare_field("best_width", want.box.width, box.width);
         compare_field("best_height", want.box.height, box.height);
      endfunction

      function int pending();
         return expected_picks.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   bius_req_if req_chan ();
   bius_rsp_if rsp_chan ();

   iou_pick_tracker tracker = new();
   bius_rect_type   prev_cand = '0;
   int              cycles = 0;
   int              hold_reqs = 0;
   int              hold_seen = 0;
   int              hold_left = 0;
   bit              steady_run = 1'b0;

   best_iou_roi_selector_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Result side: check accepted beats, random stalls, long hold-off on request
   always @(posedge clock) begin
      bius_rect_type seen_box;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_box.left   = rsp_chan.best_left;
            seen_box.top    = rsp_chan.best_top;
            seen_box.width  = rsp_chan.best_width;
            seen_box.height = rsp_chan.best_height;
            tracker.check_pick(rsp_chan.found, seen_box);
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= steady_run || ($urandom_range(99) >= 15);
         end
      end
   end

   // Two-phase register write; psel is left high for back-to-back writes
   task automatic csr_write(bius_reg_type idx, logic [CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.write_register(idx, data);
   endtask

   task automatic set_reference(int left, int top, int width, int height);
      csr_write(REG_REF_LEFT, left);
      csr_write(REG_REF_TOP, top);
      csr_write(REG_REF_WIDTH, width);
      csr_write(REG_REF_HEIGHT, height);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Idle the input, let every owed pick come back, then let the pipe settle
   task automatic wait_results_done();
      req_chan.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_candidate(bius_rect_type cand, logic last);
      int gap;
      gap = 0;
      if (!steady_run && $urandom_range(99) < 15) gap = $urandom_range(1, 4);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.cand_left   <= cand.left;
      req_chan.cand_top    <= cand.top;
      req_chan.cand_width  <= cand.width;
      req_chan.cand_height <= cand.height;
      req_chan.group_end   <= last;
      do @(posedge clock); while (!req_chan.ready);
      tracker.note_candidate(cand, last);
      prev_cand = cand;
   endtask

   task automatic send_box(int left, int top, int width, int height, logic last);
      bius_rect_type cand;
      cand.left   = COORD_BITS'(left);
      cand.top    = COORD_BITS'(top);
      cand.width  = SIZE_BITS'(width);
      cand.height = SIZE_BITS'(height);
      send_candidate(cand, last);
   endtask

   // Mostly boxes around the reference, some exact copies and ties, some noise
   function automatic bius_rect_type make_candidate();
      bius_rect_type c;
      int            mode, span_x, span_y;
      mode   = $urandom_range(99);
      span_x = int'(tracker.ref_width) + 16;
      span_y = int'(tracker.ref_height) + 16;
      if (mode < 15) begin
         c.left   = COORD_BITS'($urandom);
         c.top    = COORD_BITS'($urandom);
         c.width  = SIZE_BITS'($urandom);
         c.height = SIZE_BITS'($urandom);
      end else if (mode < 20) begin
         c = prev_cand;
      end else if (mode < 24) begin
         c.left   = tracker.ref_left;
         c.top    = tracker.ref_top;
         c.width  = tracker.ref_width;
         c.height = tracker.ref_height;
      end else begin
         c.left   = COORD_BITS'(int'(tracker.ref_left) + int'($urandom_range(2 * span_x)) - span_x);
         c.top    = COORD_BITS'(int'(tracker.ref_top) + int'($urandom_range(2 * span_y)) - span_y);
         c.width  = SIZE_BITS'($urandom_range((2 * span_x > 4095) ? 4095 : 2 * span_x));
         c.height = SIZE_BITS'($urandom_range((2 * span_y > 4095) ? 4095 : 2 * span_y));
         if (mode < 28) c.width = '0;
         else if (mode < 32) c.height = '0;
      end
      return c;
   endfunction

   function automatic int any_coord();
      return int'($urandom_range(65535)) - 32768;
   endfunction

   initial begin
      int            phase, n;
      logic          last;
      bius_rect_type cand;

      reset                <= 1'b1;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.cand_left   <= '0;
      req_chan.cand_top    <= '0;
      req_chan.cand_width  <= '0;
      req_chan.cand_height <= '0;
      req_chan.group_end   <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: ordinary reference box
      set_reference(100, 200, 50, 40);
      send_box(100, 200, 50, 40, 1'b1);        // exact match
      send_box(0, 0, 10, 10, 1'b1);            // no overlap, nothing found
      send_box(150, 200, 30, 40, 1'b0);        // touching edge only
      send_box(90, 200, 50, 40, 1'b0);         // equal IoU pair: first wins
      send_box(110, 200, 50, 40, 1'b1);
      send_box(100, 200, 0, 40, 1'b1);         // zero-area candidate
      send_box(105, 200, 50, 40, 1'b0);        // better first, worse second
      send_box(80, 200, 50, 40, 1'b1);
      send_box(80, 200, 50, 40, 1'b0);         // worse first, better second
      send_box(105, 200, 50, 40, 1'b1);
      send_box(-32768, -32768, 4095, 4095, 1'b1);
      send_box(32767, 32767, 4095, 4095, 1'b1);
      send_box(100, 200, 4095, 4095, 1'b1);    // candidate covers the reference
      wait_results_done();

      // Directed: reference at the top corner, edges past the coordinate range
      set_reference(32767, 32767, 4095, 4095);
      send_box(32767, 32767, 4095, 4095, 1'b1);
      send_box(32000, 32000, 4095, 4095, 1'b1);
      wait_results_done();

      // Directed: reference at the bottom corner
      set_reference(-32768, -32768, 4095, 4095);
      send_box(-32768, -32768, 1, 1, 1'b1);
      send_box(-30000, -30000, 4095, 4095, 1'b1);
      wait_results_done();

      // Directed: zero-area reference never yields a found box
      set_reference(100, 200, 0, 0);
      send_box(100, 200, 50, 40, 1'b1);
      wait_results_done();

      // Random phases, each with its own reference box
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_reference(-32768, -32768, 4095, 4095);
            1: set_reference(32767, 32767, 4095, 4095);
            2: set_reference(any_coord(), any_coord(), $urandom_range(1, 200),
                             $urandom_range(1, 200));
            3: set_reference(any_coord(), any_coord(), 0, $urandom_range(4095));
            4: set_reference(any_coord(), any_coord(), $urandom_range(4095),
                             $urandom_range(4095));
            5: set_reference(any_coord(), any_coord(), $urandom_range(1, 8),
                             $urandom_range(1, 8));
            6: set_reference(any_coord(), any_coord(), $urandom_range(4095), 0);
            default: set_reference(any_coord(), any_coord(), $urandom_range(1, 600),
                                   $urandom_range(1, 600));
         endcase
         steady_run <= (phase == 4);
         // result side holds off while single-beat groups keep coming
         if (phase == 2) hold_reqs <= hold_reqs + 1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 5 && n == PHASE_ITEMS / 2) wait_results_done();
            cand = make_candidate();
            if (phase == 2 && n < 40) last = 1'b1;
            else if (n == PHASE_ITEMS - 1) last = 1'b1;
            else last = ($urandom_range(99) < 20);
            send_candidate(cand, last);
         end
         wait_results_done();
      end

      if (tracker.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
